[rtl/tsts_pkg.sv]
// Shared constants, types and rounding helper for the tape saturation block.
`default_nettype none

package tsts_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_EFFECT_ON   = 2'd0;
  localparam logic [1:0] REG_INPUT_GAIN  = 2'd1;
  localparam logic [1:0] REG_INTENSITY   = 2'd2;
  localparam logic [1:0] REG_OUTPUT_GAIN = 2'd3;

  localparam int CFG_W = 17;

  // Q28 datapath widths: clipped value in Q3.28 and general Q28/Q30 words
  localparam int S_W = 31;
  localparam int Q_W = 32;

  // Shaper latency in register stages
  localparam int SHAPE_LAT = 14;

  // Clip level 2.305929 in Q28
  localparam logic signed [63:0] CLIP_Q28 = 64'sd618993103;

  // Horner coefficients in Q30: 1, 1/6, 1/69, 1/2530.08, 1/224985.6, 1/9979200
  localparam logic signed [Q_W-1:0] POLY_COEF [0:5] = '{
    32'sd1073741824, 32'sd178956971, 32'sd15561476,
    32'sd424390, 32'sd4772, 32'sd108
  };

  typedef struct packed {
    logic adv;  // pipeline advances this cycle
    logic vld;  // item present at the shaper input
  } tsts_ctl_t;

  // Round half up, then arithmetic shift right; sh is a constant at each call
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic signed [63:0] w;
    w = v + (64'sd1 <<< (sh - 1));
    return w >>> sh;
  endfunction

endpackage

`default_nettype wire

[rtl/tsts_shaper.sv]
// Pipelined odd polynomial shaper: wet = s * P(s*s), Q28 in and out.
`default_nettype none

module tsts_shaper (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire tsts_pkg::tsts_ctl_t               ctl,
  input  wire logic signed [tsts_pkg::S_W-1:0]   s_in,
  output logic signed [tsts_pkg::Q_W-1:0]        wet,
  output logic                                   wet_valid
);
  import tsts_pkg::*;

  localparam int LAST = SHAPE_LAT - 1;

  logic                    vld [0:LAST];
  logic signed [61:0]      psq;
  logic signed [S_W-1:0]   s_l  [0:11];
  logic signed [Q_W-1:0]   xx_l [0:8];
  logic signed [63:0]      prod [0:4];
  logic signed [Q_W-1:0]   acc  [0:4];
  logic signed [Q_W-1:0]   a_src [0:4];
  logic signed [62:0]      pw;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LAST; i++) vld[i] <= 1'b0;
    end else if (ctl.adv) begin
      vld[0] <= ctl.vld;
      for (int i = 1; i <= LAST; i++) vld[i] <= vld[i-1];
    end
  end

  // square, delay lines, final product
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      psq     <= s_in * s_in;
      s_l[0]  <= s_in;
      for (int i = 1; i < 12; i++) s_l[i] <= s_l[i-1];
      xx_l[0] <= Q_W'(rnd_shift(64'(psq), 28));
      for (int i = 1; i < 9; i++) xx_l[i] <= xx_l[i-1];
      pw      <= s_l[11] * acc[4];
      wet     <= Q_W'(rnd_shift(64'(pw), 30));
    end
  end

  // Horner steps: multiply stage, then subtract-from-coefficient stage
  for (genvar j = 0; j < 5; j++) begin : g_horner
    if (j == 0) begin : g_first
      assign a_src[j] = POLY_COEF[5];
    end else begin : g_next
      assign a_src[j] = acc[j-1];
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        prod[j] <= xx_l[2*j] * a_src[j];
        acc[j]  <= POLY_COEF[4-j] - Q_W'(rnd_shift(prod[j], 28));
      end
    end
  end

  assign wet_valid = vld[LAST];

endmodule

`default_nettype wire

[rtl/tape_saturation_taylor_sine.sv]
// Top level: tape-style soft saturation, one sample per cycle unless stalled, deep pipeline.
`default_nettype none

// Channel   Dir  Transfer when            Contents
// s_axis    in   s_tvalid & s_tready      sample_in, Q1.(SAMPLE_BITS-1)
// m_axis    out  m_tvalid & m_tready      sample_out, Q1.(SAMPLE_BITS-1), saturated
// cfg       in   cfg_we                   register index cfg_addr, value cfg_data
//
// Throughput is one sample per cycle unless stalled. An input transfer reaches
// m_tvalid through 4 gain/clip stages, 14 shaper stages, 4 mix/trim stages and
// the output register. Reset clears all valid bits and loads the register
// defaults. A stall on m_tready parks one result in a skid register; s_tready
// then drops (it is registered) and the whole pipeline holds.

module tape_saturation_taylor_sine #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // slave side, tdata: [SAMPLE_BITS-1:0] sample_in
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
  // master side, tdata: [SAMPLE_BITS-1:0] sample_out
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]        m_tdata,
  // configuration write port
  input  wire logic                               cfg_we,
  input  wire logic [1:0]                         cfg_addr,
  input  wire logic [tsts_pkg::CFG_W-1:0]         cfg_data
);
  import tsts_pkg::*;

  localparam int SB        = SAMPLE_BITS;
  localparam int TW        = ((SB + 7) / 8) * 8;
  localparam int FRAC_BITS = SB - 1;
  localparam int DRY_SH    = FRAC_BITS + 15 - 28;
  localparam int RSH       = (FRAC_BITS < 28) ? (28 - FRAC_BITS) : 1;
  localparam int LSH       = (FRAC_BITS > 28) ? (FRAC_BITS - 28) : 0;
  localparam logic signed [63:0] LIM_HI = (64'sd1 <<< (SB - 1)) - 64'sd1;
  localparam logic signed [63:0] LIM_LO = -(64'sd1 <<< (SB - 1));

  // ---------------- configuration registers ----------------
  logic        effect_on;
  logic [16:0] input_gain;
  logic [15:0] intensity;
  logic [14:0] output_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_on   <= 1'b1;
      input_gain  <= 17'd32768;
      intensity   <= 16'd0;
      output_gain <= 15'd29491;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_EFFECT_ON:   effect_on   <= cfg_data[0];
        REG_INPUT_GAIN:  input_gain  <= cfg_data[16:0];
        REG_INTENSITY:   intensity   <= cfg_data[15:0];
        REG_OUTPUT_GAIN: output_gain <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Derived weights, refreshed every cycle (the user keeps config moves to idle; the block does not enforce it)
  logic signed [18:0] boost;   // 1 + 2*intensity, Q15
  logic signed [17:0] w_dry;   // 1 - intensity, Q15

  always_ff @(posedge clk) begin
    boost <= 19'(32768) + 19'({intensity, 1'b0});
    w_dry <= 18'sd32768 - $signed({2'b00, intensity});
  end

  // ---------------- flow control ----------------
  logic          adv;
  logic          skid_valid;
  logic [SB-1:0] skid_data;

  assign adv      = !skid_valid;
  assign s_tready = adv;

  // ---------------- front stages: gain, boost, clip ----------------
  logic                   vld_a, vld_b, vld_c, vld_d;
  logic signed [SB+17:0]  pgain_a;
  logic signed [Q_W-1:0]  dry_b, dry_c, dry_d;
  logic signed [Q_W+18:0] pboost_c;
  logic signed [S_W-1:0]  s_d;
  logic [SB-1:0]          raw_a, raw_b, raw_c, raw_d;
  logic signed [63:0]     drv;

  assign drv = rnd_shift(64'(pboost_c), 15);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
      vld_d <= 1'b0;
    end else if (adv) begin
      vld_a <= s_tvalid;
      vld_b <= vld_a;
      vld_c <= vld_b;
      vld_d <= vld_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pgain_a  <= $signed(s_tdata[SB-1:0]) * $signed({1'b0, input_gain});
      raw_a    <= s_tdata[SB-1:0];
      dry_b    <= Q_W'(rnd_shift(64'(pgain_a), DRY_SH));
      raw_b    <= raw_a;
      pboost_c <= dry_b * boost;
      dry_c    <= dry_b;
      raw_c    <= raw_b;
      if (drv > CLIP_Q28)
        s_d <= S_W'(CLIP_Q28);
      else if (drv < -CLIP_Q28)
        s_d <= S_W'(-CLIP_Q28);
      else
        s_d <= S_W'(drv);
      dry_d    <= dry_c;
      raw_d    <= raw_c;
    end
  end

  // ---------------- shaper and matching delay lines ----------------
  tsts_ctl_t             sh_ctl;
  logic signed [Q_W-1:0] wet;
  logic                  wet_valid;

  assign sh_ctl.adv = adv;
  assign sh_ctl.vld = vld_d;

  tsts_shaper u_shaper (
    .clk       (clk),
    .rst       (rst),
    .ctl       (sh_ctl),
    .s_in      (s_d),
    .wet       (wet),
    .wet_valid (wet_valid)
  );

  logic signed [Q_W-1:0] dry_l [0:SHAPE_LAT-1];
  logic [SB-1:0]         raw_l [0:SHAPE_LAT-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dry_l[0] <= dry_d;
      raw_l[0] <= raw_d;
      for (int i = 1; i < SHAPE_LAT; i++) begin
        dry_l[i] <= dry_l[i-1];
        raw_l[i] <= raw_l[i-1];
      end
    end
  end

  // ---------------- back stages: wet/dry blend, trim, saturate ----------------
  logic                  vld_e, vld_f, vld_g, vld_h;
  logic signed [49:0]    pdry_e;
  logic signed [48:0]    pwet_e;
  logic signed [35:0]    mix_f;
  logic signed [51:0]    pout_g;
  logic signed [39:0]    o28_h;
  logic [SB-1:0]         raw_e, raw_f, raw_g, raw_h;
  logic signed [63:0]    yw;
  logic [SB-1:0]         y;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_e <= 1'b0;
      vld_f <= 1'b0;
      vld_g <= 1'b0;
      vld_h <= 1'b0;
    end else if (adv) begin
      vld_e <= wet_valid;
      vld_f <= vld_e;
      vld_g <= vld_f;
      vld_h <= vld_g;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pdry_e <= dry_l[SHAPE_LAT-1] * w_dry;
      pwet_e <= wet * $signed({1'b0, intensity});
      raw_e  <= raw_l[SHAPE_LAT-1];
      mix_f  <= 36'(rnd_shift(64'(pdry_e) + 64'(pwet_e), 15));
      raw_f  <= raw_e;
      pout_g <= mix_f * $signed({1'b0, output_gain});
      raw_g  <= raw_f;
      o28_h  <= 40'(rnd_shift(64'(pout_g), 15));
      raw_h  <= raw_g;
    end
  end

  // Q28 to output format, then saturate; bypass picks the raw sample
  always_comb begin
    if (FRAC_BITS < 28)
      yw = rnd_shift(64'(o28_h), RSH);
    else
      yw = 64'(o28_h) <<< LSH;

    if (!effect_on)
      y = raw_h;
    else if (yw > LIM_HI)
      y = LIM_HI[SB-1:0];
    else if (yw < LIM_LO)
      y = LIM_LO[SB-1:0];
    else
      y = yw[SB-1:0];
  end

  // ---------------- output register and skid ----------------
  logic [SB-1:0] out_data;
  logic          load_out, load_skid, out_take;

  assign out_take  = m_tvalid && m_tready;
  assign load_out  = adv && vld_h && (!m_tvalid || m_tready);
  assign load_skid = adv && vld_h && m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) skid_valid <= 1'b0;
      end else if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (load_skid) begin
        skid_valid <= 1'b1;
      end else if (out_take) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) out_data <= skid_data;
    end else if (load_out) begin
      out_data <= y;
    end
    if (load_skid) skid_data <= y;
  end

  assign m_tdata = TW'(out_data);

endmodule

`default_nettype wire
